### hdl/frame_time_window_stats_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame time window statistics block
// Shared property wrappers; every check is clocked on clk and is off in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_WINDOW_STATS_TOP_DEFINES_SVH
`define FRAME_TIME_WINDOW_STATS_TOP_DEFINES_SVH

// Same-cycle implication.
`define FTWS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FTWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ftws_pkg.sv
// ----------------------------------------------------------------------------
// Frame time window statistics package
// Sizes, register indexes, class codes and shared types.
// ----------------------------------------------------------------------------
package ftws_pkg;

  localparam int BKT_COUNT = 60;
  localparam int BKT_IDX_W = $clog2(BKT_COUNT);
  localparam int MOD_W     = BKT_IDX_W + 1;

  localparam int RENDER_W  = 32;
  localparam int TS_W      = 64;
  localparam int TIME_W    = 16;
  localparam int RATE_W    = 16;
  localparam int CLASS_W   = 2;
  localparam int FRAMES_W  = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int MS_PER_S  = 1000;
  localparam int PROD_W    = FRAMES_W + 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUCKET_PERIOD = 3'd0,
    REG_RATE_WINDOW   = 3'd1,
    REG_BUDGET        = 3'd2,
    REG_WARN          = 3'd3,
    REG_RATE_GOOD     = 3'd4,
    REG_RATE_WARN     = 3'd5
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_BUCKET_PERIOD = 16'd500;
  localparam logic [CFG_W-1:0] RST_RATE_WINDOW   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_BUDGET        = 16'd16667;
  localparam logic [CFG_W-1:0] RST_WARN          = 16'd10000;
  localparam logic [CFG_W-1:0] RST_RATE_GOOD     = 16'd50;
  localparam logic [CFG_W-1:0] RST_RATE_WARN     = 16'd25;

  localparam logic [CLASS_W-1:0] CLS_GOOD = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_WARN = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_OVER = 2'd2;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### hdl/ftws_in_if.sv
// ----------------------------------------------------------------------------
// Frame request channel
// Valid/ready channel carrying one frame's render time and timestamp.
// ----------------------------------------------------------------------------
interface ftws_in_if;
  import ftws_pkg::*;

  logic                valid;
  logic                ready;
  logic [RENDER_W-1:0] render_time_us;
  logic [TS_W-1:0]     timestamp_ms;

  modport source (output valid, output render_time_us, output timestamp_ms, input ready);
  modport sink   (input valid, input render_time_us, input timestamp_ms, output ready);
endinterface

### hdl/ftws_out_if.sv
// ----------------------------------------------------------------------------
// Statistics result channel
// Valid/ready channel carrying the frame rate and window statistics.
// ----------------------------------------------------------------------------
interface ftws_out_if;
  import ftws_pkg::*;

  logic               valid;
  logic               ready;
  logic [RATE_W-1:0]  frame_rate;
  logic [CLASS_W-1:0] rate_class;
  logic [TIME_W-1:0]  window_min_us;
  logic [TIME_W-1:0]  window_max_us;
  logic [CLASS_W-1:0] max_class;
  logic               window_empty;

  modport source (output valid, output frame_rate, output rate_class, output window_min_us,
                  output window_max_us, output max_class, output window_empty, input ready);
  modport sink   (input valid, input frame_rate, input rate_class, input window_min_us,
                  input window_max_us, input max_class, input window_empty, output ready);
endinterface

### hdl/ftws_divider.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle; also tracks the quotient modulo the bucket count.
// ----------------------------------------------------------------------------
module ftws_divider
  import ftws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder,
  output logic [MOD_W-1:0] quo_mod
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [MOD_W-1:0]     mod_r, mod_nxt;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             qbit;
  logic [MOD_W-1:0] mod_sh;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DIV_W-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    qbit     = ~diff[DIV_W];
    mod_sh   = {mod_r[MOD_W-2:0], qbit};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    mod_nxt  = mod_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      mod_nxt  = '0;
    end else if (busy_r) begin
      // The quotient bits enter at the bottom of the dividend register.
      dvd_nxt = {dvd_r[DIV_W-2:0], qbit};
      rem_nxt = qbit ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      mod_nxt = (mod_sh >= MOD_W'(BKT_COUNT)) ? mod_sh - MOD_W'(BKT_COUNT) : mod_sh;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    mod_r <= mod_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;
  assign quo_mod   = mod_r;

endmodule

### hdl/frame_time_window_stats_top.sv
// ----------------------------------------------------------------------------
// Frame time window statistics, top level
// Bucketed render time history and frame rate, one result per frame request.
// ----------------------------------------------------------------------------
// Each request on in_ch carries one frame: its render time in microseconds and
// a millisecond timestamp. The block answers every request with exactly one
// result on out_ch: the last computed frame rate and its class, and the min and
// max render time over the filled history buckets with the class of the max.
// Both channels are valid/ready; a request or result moves on a clock edge with
// valid and ready high. Configuration registers are written on cfg_we with
// cfg_idx selecting the register; they should only change while no request is
// in flight.
// in_ch.ready rises at the edge that loads a request's result, so the block takes
// a new request only once the last one is through. The shared 64-bit divider
// sets the pace: first the bucket period count, then, when it is recomputed, the
// frame rate, the latter overlapped with the scan of the 60 buckets through the
// single read port of the bucket memories.
// Reset (synchronous, rst_n low) empties every bucket through its valid flop,
// clears the windows and loads the default registers; no clearing pass is
// needed. The result sits in an output register, so a new request is accepted
// while a result waits; a stalled receiver only holds the block when a second
// result is ready to be loaded.
// ----------------------------------------------------------------------------
`include "frame_time_window_stats_top_defines.svh"

module frame_time_window_stats_top
  import ftws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ftws_in_if.sink              in_ch,
  ftws_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV1,
    ST_RETIRE,
    ST_RDHEAD,
    ST_WRHEAD,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_RATE_WAIT,
    ST_EMIT
  } state_t;

  // Render time class against the budget and warning thresholds.
  function automatic logic [CLASS_W-1:0] time_class(input logic [TIME_W-1:0] t,
                                                    input logic [CFG_W-1:0]  budget,
                                                    input logic [CFG_W-1:0]  warn);
    logic [CLASS_W-1:0] c;
    if (t >= budget) c = CLS_OVER;
    else if (t >= warn) c = CLS_WARN;
    else c = CLS_GOOD;
    return c;
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] period_cfg_r, rwin_cfg_r, budget_r, warn_r, rate_good_r, rate_warn_r;

  // Control and window state.
  state_t                 state_r, state_nxt;
  logic                   anchored_r, anchored_nxt;
  logic [BKT_IDX_W-1:0]   head_r, head_nxt;
  logic [BKT_COUNT-1:0]   valid_r, valid_nxt;
  logic [TS_W-1:0]        bstart_r, bstart_nxt;
  logic [TS_W-1:0]        rstart_r, rstart_nxt;
  logic [FRAMES_W-1:0]    frames_r, frames_nxt;
  logic [RATE_W-1:0]      rate_r, rate_nxt;
  logic                   rate_go_r, rate_go_nxt;

  // Per-request working registers.
  logic [TS_W-1:0]        now_r, now_nxt;
  logic [TIME_W-1:0]      t_r, t_nxt;
  logic [TS_W-1:0]        elapsed_r, elapsed_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;

  // Scan pipeline and accumulators.
  logic [BKT_IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                   pend_r, pend_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic                   any_r, any_nxt;
  logic [TIME_W-1:0]      vmin_r, vmin_nxt;
  logic [TIME_W-1:0]      vmax_r, vmax_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0]      o_rate_r, o_rate_nxt;
  logic [CLASS_W-1:0]     o_rcls_r, o_rcls_nxt;
  logic [TIME_W-1:0]      o_min_r, o_min_nxt;
  logic [TIME_W-1:0]      o_max_r, o_max_nxt;
  logic [CLASS_W-1:0]     o_mcls_r, o_mcls_nxt;
  logic                   o_empty_r, o_empty_nxt;

  // Bucket memories, one write and one read port, registered read data.
  logic [TIME_W-1:0]      high_mem [BKT_COUNT];
  logic [TIME_W-1:0]      low_mem  [BKT_COUNT];
  logic [TIME_W-1:0]      rd_high_r, rd_low_r;
  logic [BKT_IDX_W-1:0]   rd_addr;
  logic                   mem_we;
  logic [TIME_W-1:0]      wr_high, wr_low;

  // Divider hookup.
  logic                   div_start;
  logic [DIV_W-1:0]       div_dvd, div_dsr;
  div_sts_t               div_sts;
  logic [DIV_W-1:0]       div_quo, div_rem;
  logic [MOD_W-1:0]       div_mod;

  logic [CFG_W-1:0]       period_eff, rwin_eff;
  logic [TIME_W-1:0]      t_clamp;
  logic [MOD_W-1:0]       head_sum;
  logic [BKT_COUNT-1:0]   clr_mask;
  logic [MOD_W-1:0]       ring_gap;
  logic                   cur_vld;

  ftws_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem),
    .quo_mod   (div_mod)
  );

  // A zero period behaves as one millisecond.
  assign period_eff = (period_cfg_r == '0) ? CFG_W'(1) : period_cfg_r;
  assign rwin_eff   = (rwin_cfg_r == '0) ? CFG_W'(1) : rwin_cfg_r;

  always_comb begin
    if (in_ch.render_time_us == '0) t_clamp = TIME_W'(1);
    else if (|in_ch.render_time_us[RENDER_W-1:TIME_W]) t_clamp = '1;
    else t_clamp = in_ch.render_time_us[TIME_W-1:0];
  end

  // Buckets retired by a short gap: those one to k places past the old head.
  always_comb begin
    for (int i = 0; i < BKT_COUNT; i++) begin
      if (MOD_W'(i) >= {1'b0, head_r}) ring_gap = MOD_W'(i) - {1'b0, head_r};
      else ring_gap = MOD_W'(i) + MOD_W'(BKT_COUNT) - {1'b0, head_r};
      clr_mask[i] = (ring_gap != '0) && (ring_gap <= div_quo[MOD_W-1:0]);
    end
  end

  assign head_sum = {1'b0, head_r} + div_mod;
  assign cur_vld  = valid_r[head_r];

  always_comb begin
    state_nxt     = state_r;
    anchored_nxt  = anchored_r;
    head_nxt      = head_r;
    valid_nxt     = valid_r;
    bstart_nxt    = bstart_r;
    rstart_nxt    = rstart_r;
    frames_nxt    = frames_r;
    rate_nxt      = rate_r;
    rate_go_nxt   = rate_go_r;
    now_nxt       = now_r;
    t_nxt         = t_r;
    elapsed_nxt   = elapsed_r;
    prod_nxt      = prod_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = 1'b0;
    rd_vld_nxt    = rd_vld_r;
    any_nxt       = any_r;
    vmin_nxt      = vmin_r;
    vmax_nxt      = vmax_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    o_rate_nxt    = o_rate_r;
    o_rcls_nxt    = o_rcls_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    o_mcls_nxt    = o_mcls_r;
    o_empty_nxt   = o_empty_r;
    rd_addr       = scan_idx_r;
    mem_we        = 1'b0;
    wr_high       = t_r;
    wr_low        = t_r;
    div_start     = 1'b0;
    div_dvd       = TS_W'(now_r - bstart_r);
    div_dsr       = DIV_W'(period_eff);

    // Scan data lands in the cycle after its address was issued.
    if (pend_r && rd_vld_r) begin
      any_nxt = 1'b1;
      if (rd_low_r < vmin_r) vmin_nxt = rd_low_r;
      if (rd_high_r > vmax_r) vmax_nxt = rd_high_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          now_nxt = in_ch.timestamp_ms;
          t_nxt   = t_clamp;
          // First frame, or time went backwards: re-anchor both windows.
          if (!anchored_r || (in_ch.timestamp_ms < bstart_r)) begin
            anchored_nxt = 1'b1;
            bstart_nxt   = in_ch.timestamp_ms;
            rstart_nxt   = in_ch.timestamp_ms;
          end
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        div_start   = 1'b1;
        elapsed_nxt = now_r - rstart_r;
        prod_nxt    = PROD_W'(frames_r + 1'b1) * PROD_W'(MS_PER_S);
        state_nxt   = ST_DIV1;
      end
      ST_DIV1: begin
        if (div_sts.done) state_nxt = ST_RETIRE;
      end
      ST_RETIRE: begin
        head_nxt   = (head_sum >= MOD_W'(BKT_COUNT)) ?
                     BKT_IDX_W'(head_sum - MOD_W'(BKT_COUNT)) : head_sum[BKT_IDX_W-1:0];
        // Start moves by whole periods: the timestamp less the remainder.
        bstart_nxt = now_r - div_rem;
        if (div_quo >= DIV_W'(BKT_COUNT)) valid_nxt = '0;
        else valid_nxt = valid_r & ~clr_mask;
        state_nxt  = ST_RDHEAD;
      end
      ST_RDHEAD: begin
        rd_addr   = head_r;
        state_nxt = ST_WRHEAD;
      end
      ST_WRHEAD: begin
        mem_we = 1'b1;
        if (cur_vld) begin
          wr_high = (t_r > rd_high_r) ? t_r : rd_high_r;
          wr_low  = (t_r < rd_low_r) ? t_r : rd_low_r;
        end
        valid_nxt[head_r] = 1'b1;
        if (elapsed_r >= TS_W'(rwin_eff)) begin
          rate_go_nxt = 1'b1;
          div_start   = 1'b1;
          div_dvd     = TS_W'(prod_r) + (elapsed_r >> 1);
          div_dsr     = elapsed_r;
          frames_nxt  = '0;
          rstart_nxt  = now_r;
        end else begin
          rate_go_nxt = 1'b0;
          frames_nxt  = frames_r + 1'b1;
        end
        scan_idx_nxt = '0;
        any_nxt      = 1'b0;
        vmin_nxt     = '1;
        vmax_nxt     = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        pend_nxt   = 1'b1;
        rd_vld_nxt = valid_r[scan_idx_r];
        if (scan_idx_r == BKT_IDX_W'(BKT_COUNT - 1)) state_nxt = ST_SCAN_TAIL;
        else scan_idx_nxt = scan_idx_r + 1'b1;
      end
      ST_SCAN_TAIL: begin
        state_nxt = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (!div_sts.busy) begin
          if (rate_go_r) begin
            rate_nxt = (|div_quo[DIV_W-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_rate_nxt    = rate_r;
          if (rate_r >= rate_good_r) o_rcls_nxt = CLS_GOOD;
          else if (rate_r >= rate_warn_r) o_rcls_nxt = CLS_WARN;
          else o_rcls_nxt = CLS_OVER;
          o_empty_nxt = ~any_r;
          o_min_nxt   = any_r ? vmin_r : '0;
          o_max_nxt   = any_r ? vmax_r : '0;
          o_mcls_nxt  = any_r ? time_class(vmax_r, budget_r, warn_r) : CLS_GOOD;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      anchored_r   <= 1'b0;
      head_r       <= '0;
      valid_r      <= '0;
      bstart_r     <= '0;
      rstart_r     <= '0;
      frames_r     <= '0;
      rate_r       <= '0;
      rate_go_r    <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      period_cfg_r <= RST_BUCKET_PERIOD;
      rwin_cfg_r   <= RST_RATE_WINDOW;
      budget_r     <= RST_BUDGET;
      warn_r       <= RST_WARN;
      rate_good_r  <= RST_RATE_GOOD;
      rate_warn_r  <= RST_RATE_WARN;
    end else begin
      state_r     <= state_nxt;
      anchored_r  <= anchored_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      bstart_r    <= bstart_nxt;
      rstart_r    <= rstart_nxt;
      frames_r    <= frames_nxt;
      rate_r      <= rate_nxt;
      rate_go_r   <= rate_go_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_BUCKET_PERIOD: period_cfg_r <= cfg_data;
          REG_RATE_WINDOW:   rwin_cfg_r   <= cfg_data;
          REG_BUDGET:        budget_r     <= cfg_data;
          REG_WARN:          warn_r       <= cfg_data;
          REG_RATE_GOOD:     rate_good_r  <= cfg_data;
          REG_RATE_WARN:     rate_warn_r  <= cfg_data;
          default: ;
        endcase
      end
    end
    now_r      <= now_nxt;
    t_r        <= t_nxt;
    elapsed_r  <= elapsed_nxt;
    prod_r     <= prod_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_vld_r   <= rd_vld_nxt;
    any_r      <= any_nxt;
    vmin_r     <= vmin_nxt;
    vmax_r     <= vmax_nxt;
    o_rate_r   <= o_rate_nxt;
    o_rcls_r   <= o_rcls_nxt;
    o_min_r    <= o_min_nxt;
    o_max_r    <= o_max_nxt;
    o_mcls_r   <= o_mcls_nxt;
    o_empty_r  <= o_empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      high_mem[head_r] <= wr_high;
      low_mem[head_r]  <= wr_low;
    end
    rd_high_r <= high_mem[rd_addr];
    rd_low_r  <= low_mem[rd_addr];
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_rate    = o_rate_r;
  assign out_ch.rate_class    = o_rcls_r;
  assign out_ch.window_min_us = o_min_r;
  assign out_ch.window_max_us = o_max_r;
  assign out_ch.max_class     = o_mcls_r;
  assign out_ch.window_empty  = o_empty_r;

  // An accepted request keeps the block busy for the next cycle.
  `FTWS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
                    "request accepted while the previous one is in flight")
  // The shared divider is never restarted in the middle of a division.
  `FTWS_ASSERT_IMPL(a_div_no_restart, div_start, !div_sts.busy,
                    "divider started while busy")
  // Lows and highs are written together, so a filled window has min at most max.
  `FTWS_ASSERT_IMPL(a_min_le_max, out_valid_r && !o_empty_r, o_min_r <= o_max_r,
                    "window minimum above window maximum")

endmodule

### test/tb_frame_time_window_stats_top.sv
// ----------------------------------------------------------------------------
// Testbench for the frame time window statistics block
// Drives frame requests through several register settings and idle patterns,
// predicts every result in a scoreboard and compares each one field by field.
// ----------------------------------------------------------------------------
module tb_frame_time_window_stats_top;
  import ftws_pkg::*;

  // One expected or observed result of the block.
  typedef struct packed {
    logic [RATE_W-1:0]  frame_rate;
    logic [CLASS_W-1:0] rate_class;
    logic [TIME_W-1:0]  window_min_us;
    logic [TIME_W-1:0]  window_max_us;
    logic [CLASS_W-1:0] max_class;
    logic               window_empty;
  } stats_t;

  // The scoreboard keeps its own copy of the bucket history, the rate window
  // and the registers, and queues the statistics each accepted frame yields.
  class frame_stats_scoreboard;
    logic [TIME_W-1:0]   bucket_max [BKT_COUNT];
    logic [TIME_W-1:0]   bucket_min [BKT_COUNT];
    int unsigned         head;
    bit                  anchored;
    logic [TS_W-1:0]     bucket_origin;
    logic [FRAMES_W-1:0] frame_count;
    logic [TS_W-1:0]     rate_origin;
    logic [RATE_W-1:0]   rate_fps;
    logic [CFG_W-1:0]    period_ms, window_ms, budget, warn_level, good_fps, warn_fps;
    stats_t              pending_stats [$];
    int                  results_checked;
    int                  mismatches;

    function new();
      foreach (bucket_max[i]) begin
        bucket_max[i] = '0;
        bucket_min[i] = '0;
      end
      head          = 0;
      anchored      = 0;
      bucket_origin = '0;
      frame_count   = '0;
      rate_origin   = '0;
      rate_fps      = '0;
      period_ms     = RST_BUCKET_PERIOD;
      window_ms     = RST_RATE_WINDOW;
      budget        = RST_BUDGET;
      warn_level    = RST_WARN;
      good_fps      = RST_RATE_GOOD;
      warn_fps      = RST_RATE_WARN;
      results_checked = 0;
      mismatches      = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_BUCKET_PERIOD: period_ms  = value;
        REG_RATE_WINDOW:   window_ms  = value;
        REG_BUDGET:        budget     = value;
        REG_WARN:          warn_level = value;
        REG_RATE_GOOD:     good_fps   = value;
        REG_RATE_WARN:     warn_fps   = value;
        default: ;
      endcase
    endfunction

    function logic [CLASS_W-1:0] render_class(logic [TIME_W-1:0] t);
      if (t >= budget) return CLS_OVER;
      if (t >= warn_level) return CLS_WARN;
      return CLS_GOOD;
    endfunction

    // Advances the history by one frame and returns the statistics it yields.
    function stats_t window_stats(logic [RENDER_W-1:0] render, logic [TS_W-1:0] now);
      logic [TS_W-1:0]   period;
      logic [TS_W-1:0]   rate_span;
      logic [TS_W-1:0]   periods;
      logic [TS_W-1:0]   elapsed;
      logic [TS_W-1:0]   fps;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
      bit                any;
      stats_t            s;

      period    = (period_ms == 0) ? 64'd1 : 64'(period_ms);
      rate_span = (window_ms == 0) ? 64'd1 : 64'(window_ms);

      // A timestamp behind the bucket start re-anchors both windows.
      if (anchored && now < bucket_origin) anchored = 0;
      if (!anchored) begin
        anchored      = 1;
        bucket_origin = now;
        rate_origin   = now;
      end

      // Retire one bucket per elapsed period; a long gap clears them all.
      periods = (now - bucket_origin) / period;
      if (periods != 0) begin
        if (periods >= BKT_COUNT) begin
          foreach (bucket_max[i]) bucket_max[i] = '0;
        end else begin
          for (int i = 1; i <= int'(periods); i++) bucket_max[(head + i) % BKT_COUNT] = '0;
        end
        head          = (head + int'(periods % BKT_COUNT)) % BKT_COUNT;
        bucket_origin = bucket_origin + periods * period;
      end

      if (render == 0) t = 16'd1;
      else if (render > 32'd65535) t = 16'hFFFF;
      else t = render[TIME_W-1:0];

      if (bucket_max[head] == 0) begin
        bucket_max[head] = t;
        bucket_min[head] = t;
      end else begin
        if (t > bucket_max[head]) bucket_max[head] = t;
        if (t < bucket_min[head]) bucket_min[head] = t;
      end

      // The elapsed time wraps when the timestamp falls behind the rate start.
      frame_count = frame_count + 1;
      elapsed     = now - rate_origin;
      if (elapsed >= rate_span) begin
        fps         = (64'(frame_count) * 64'd1000 + elapsed / 2) / elapsed;
        rate_fps    = (fps > 64'd65535) ? 16'hFFFF : fps[RATE_W-1:0];
        frame_count = '0;
        rate_origin = now;
      end

      lo  = 16'hFFFF;
      hi  = '0;
      any = 0;
      foreach (bucket_max[i]) begin
        if (bucket_max[i] != 0) begin
          any = 1;
          if (bucket_min[i] < lo) lo = bucket_min[i];
          if (bucket_max[i] > hi) hi = bucket_max[i];
        end
      end

      s.frame_rate = rate_fps;
      if (rate_fps >= good_fps) s.rate_class = CLS_GOOD;
      else if (rate_fps >= warn_fps) s.rate_class = CLS_WARN;
      else s.rate_class = CLS_OVER;
      if (any) begin
        s.window_min_us = lo;
        s.window_max_us = hi;
        s.max_class     = render_class(hi);
        s.window_empty  = 1'b0;
      end else begin
        s.window_min_us = '0;
        s.window_max_us = '0;
        s.max_class     = CLS_GOOD;
        s.window_empty  = 1'b1;
      end
      return s;
    endfunction

    function void note_frame(logic [RENDER_W-1:0] render, logic [TS_W-1:0] now);
      pending_stats.push_back(window_stats(render, now));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", results_checked, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_stats(stats_t got);
      stats_t want;
      if (pending_stats.size() == 0) begin
        report_mismatch("result with no frame request waiting");
        return;
      end
      want = pending_stats.pop_front();
      results_checked++;
      compare_field("frame_rate", got.frame_rate, want.frame_rate);
      compare_field("rate_class", 16'(got.rate_class), 16'(want.rate_class));
      compare_field("window_min_us", got.window_min_us, want.window_min_us);
      compare_field("window_max_us", got.window_max_us, want.window_max_us);
      compare_field("max_class", 16'(got.max_class), 16'(want.max_class));
      compare_field("window_empty", 16'(got.window_empty), 16'(want.window_empty));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 result_ready = 1'b0;

  ftws_in_if  in_bus ();
  ftws_out_if out_bus ();

  assign out_bus.ready = result_ready;

  frame_stats_scoreboard board = new();

  // Idle percentages of the sender and the receiver, changed between phases.
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          frames_sent = 0;
  int          settings_used = 1;
  // Effective periods of the current settings, used to shape timestamps.
  int unsigned cur_period = 500;
  int unsigned cur_window = 1000;
  logic [TS_W-1:0] clock_ms = '0;

  frame_time_window_stats_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random according to the current idle percentage.
  always @(posedge clk) begin
    result_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  // Every result that moves is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      board.check_stats('{out_bus.frame_rate, out_bus.rate_class, out_bus.window_min_us,
                          out_bus.window_max_us, out_bus.max_class, out_bus.window_empty});
    end
  end

  // Backstop against a hung block; the slowest correct run is far shorter.
  initial begin
    #30000000;
    $display("Timeout with %0d results still expected.", board.pending_stats.size());
    $display("** frame_time_window_stats_top: FAILED **");
    $finish;
  end

  // Presents one frame request, after a random idle gap, and holds it until
  // the block takes it. Valid stays high afterwards so back-to-back requests
  // never see valid dropped and raised within one step.
  task automatic send_frame(input logic [RENDER_W-1:0] render, input logic [TS_W-1:0] ts);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.render_time_us <= render;
    in_bus.timestamp_ms   <= ts;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    board.note_frame(render, ts);
    frames_sent++;
    clock_ms = ts;
  endtask

  // Lowers valid once the stimulus of a phase is through and waits until
  // every predicted result has come back, so the block is idle again.
  task automatic drain;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_stats.size() != 0) @(posedge clk);
  endtask

  // cfg_we stays high across a burst of register writes and is lowered after
  // the last one.
  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] window,
                                input logic [CFG_W-1:0] budget, input logic [CFG_W-1:0] warn,
                                input logic [CFG_W-1:0] good_fps, input logic [CFG_W-1:0] warn_fps);
    put_reg(REG_BUCKET_PERIOD, period);
    put_reg(REG_RATE_WINDOW, window);
    put_reg(REG_BUDGET, budget);
    put_reg(REG_WARN, warn);
    put_reg(REG_RATE_GOOD, good_fps);
    put_reg(REG_RATE_WARN, warn_fps);
    cfg_we <= 1'b0;
    cur_period = (period == 0) ? 1 : period;
    cur_window = (window == 0) ? 1 : window;
    settings_used++;
  endtask

  // Render times mostly sit around the usual thresholds, with the clamp
  // edges and full-width values mixed in.
  function automatic logic [RENDER_W-1:0] pick_render();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return $urandom_range(1, 20000);
    if (pick < 75) return '0;
    if (pick < 88) return $urandom;
    return $urandom_range(65530, 65540);
  endfunction

  // Random stimulus is built from runs of frames with a common pacing: dense
  // runs, runs near the bucket or rate period, long gaps that retire the
  // whole history, and bursts at one timestamp that drive the frame rate to
  // saturation under a short rate window. Arbitrary timestamps and small
  // backward steps exercise re-anchoring and the wrapped rate window.
  task automatic run_random(input int n_frames);
    int              done_n;
    int              kind;
    int              run_len;
    int unsigned     span;
    logic [TS_W-1:0] ts;
    done_n = 0;
    while (done_n < n_frames) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        send_frame(pick_render(), {$urandom, $urandom});
        done_n++;
      end else if (kind < 14) begin
        run_len = $urandom_range(66, 90);
        for (int j = 0; j < run_len; j++) send_frame(pick_render(), clock_ms);
        send_frame(pick_render(), clock_ms + cur_window);
        done_n += run_len + 1;
      end else begin
        case ($urandom_range(4))
          0: span = 3;
          1: span = 40;
          2: span = cur_period;
          3: span = cur_window;
          default: span = 70 * cur_period;
        endcase
        run_len = $urandom_range(4, 24);
        for (int j = 0; j < run_len; j++) begin
          if ($urandom_range(99) < 5) ts = clock_ms - $urandom_range(1, cur_period);
          else ts = clock_ms + $urandom_range(0, span);
          send_frame(pick_render(), ts);
        end
        done_n += run_len;
      end
    end
  endtask

  localparam logic [TS_W-1:0] HALF = 64'h8000_0000_0000_0000;

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = REG_BUCKET_PERIOD;
    cfg_data              = '0;
    in_bus.valid          = 1'b0;
    in_bus.render_time_us = '0;
    in_bus.timestamp_ms   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset registers. The sender idles now and then
    // while the receiver stalls most of the time.
    tx_idle_pct = 9;
    rx_idle_pct = 80;
    // The first frame anchors both windows; render times below 1 and above
    // 65535 are clamped, and a second frame at the same time shares a bucket.
    send_frame(32'd0, 64'd1000);
    send_frame(32'hFFFF_FFFF, 64'd1000);
    send_frame(32'd65535, 64'd1200);
    send_frame(32'd65536, 64'd1499);
    // Exactly the warning and budget levels, with a bucket retired and the
    // rate recomputed for the first time.
    send_frame(32'd10000, 64'd1500);
    send_frame(32'd16667, 64'd2100);
    // Between the bucket start and the rate start: the rate window wraps.
    send_frame(32'd16666, 64'd2050);
    send_frame(32'd9999, 64'd2120);
    // A step back behind the bucket start re-anchors both windows.
    send_frame(32'd1, 64'd1000);
    // Gaps of 30 periods and of more than the whole ring.
    send_frame(32'd5000, 64'd16000);
    send_frame(32'd20000, 64'd46007);
    // Timestamp extremes: zero, all ones, then back to the midpoint.
    send_frame(32'd300, 64'd0);
    send_frame(32'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(32'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(32'd12345, HALF);
    // One period, then 59 and 60 periods: the last one clears every bucket.
    send_frame(32'h8000_0000, HALF + 64'd500);
    send_frame(32'd40000, HALF + 64'd30000);
    send_frame(32'd70, HALF + 64'd60000);
    send_frame(32'd15000, HALF + 64'd60999);
    send_frame(32'h0001_0001, HALF + 64'd62000);
    drain();

    // A typical display setup with short buckets.
    apply_settings(16'd100, 16'd1000, 16'd16667, 16'd10000, 16'd60, 16'd30);
    run_random(165);
    drain();

    // Smallest registers: one millisecond periods, every time over budget.
    apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
    run_random(165);
    drain();

    // Now the receiver idles now and then and the sender most of the time.
    tx_idle_pct = 80;
    rx_idle_pct = 9;
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(165);
    drain();

    // Zero periods behave as one millisecond.
    apply_settings(16'd0, 16'd0, 16'd20000, 16'd5000, 16'hFFFF, 16'd100);
    run_random(165);
    drain();

    // Neither side idles from here on.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                   CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                   CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
    run_random(165);
    drain();

    apply_settings(RST_BUCKET_PERIOD, RST_RATE_WINDOW, RST_BUDGET, RST_WARN, RST_RATE_GOOD,
                   RST_RATE_WARN);
    run_random(165);
    drain();

    // Give a stray late result time to show up before the verdict.
    repeat (200) @(posedge clk);

    $display("Sent %0d frame requests under %0d register settings and three idle patterns.",
             frames_sent, settings_used);
    $display("Compared %0d results, %0d mismatches.", board.results_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("** frame_time_window_stats_top: PASSED **");
    end else begin
      $display("** frame_time_window_stats_top: FAILED **");
    end
    $finish;
  end

endmodule
